@@ hdl/mtep_pkg.sv @@
package mtep_pkg;

   // Longest variable-length quantity accepted, in bytes
   localparam int MAX_LENGTH_BYTES = 4;

   localparam int LEN_W   = 28;
   localparam int COUNT_W = 3;

   typedef enum logic [2:0] {
      PH_DELTA,
      PH_STATUS,
      PH_PARAM1,
      PH_PARAM2,
      PH_METATYPE,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_DONE
   } phase_type;

   // Result kinds
   localparam logic [2:0] KIND_CHANNEL = 3'd0;
   localparam logic [2:0] KIND_SYSEX   = 3'd1;
   localparam logic [2:0] KIND_META    = 3'd2;
   localparam logic [2:0] KIND_PAYLOAD = 3'd3;
   localparam logic [2:0] KIND_ERROR   = 3'd4;

   // Error codes
   localparam logic [1:0] ERR_TOO_LONG = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

   // Status bytes and nibbles
   localparam logic [7:0] ST_SYSEX     = 8'hF0;
   localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
   localparam logic [7:0] ST_META      = 8'hFF;
   localparam logic [7:0] META_END     = 8'h2F;
   localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
   localparam logic [3:0] NIB_POLY_AT  = 4'hA;
   localparam logic [3:0] NIB_CONTROL  = 4'hB;
   localparam logic [3:0] NIB_PROGRAM  = 4'hC;
   localparam logic [3:0] NIB_CHAN_AT  = 4'hD;
   localparam logic [3:0] NIB_BEND     = 4'hE;

   typedef struct packed {
      phase_type          phase;
      logic [LEN_W-1:0]   acc;
      logic [COUNT_W-1:0] cnt;
      logic [7:0]         running;
      logic [7:0]         current;
      logic [LEN_W-1:0]   held_delta;
      logic [7:0]         held_p1;
      logic [7:0]         held_meta;
      logic [LEN_W-1:0]   remaining;
      logic               err;
   } state_type;

   // Parse state after reset: waiting for a delta time, everything else clear
   localparam state_type STATE_RESET = '{
      phase:      PH_DELTA,
      acc:        '0,
      cnt:        '0,
      running:    8'h00,
      current:    8'h00,
      held_delta: '0,
      held_p1:    8'h00,
      held_meta:  8'h00,
      remaining:  '0,
      err:        1'b0
   };

   typedef struct packed {
      logic [2:0]       event_kind;
      logic [LEN_W-1:0] delta_ticks;
      logic [7:0]       status_value;
      logic [3:0]       channel_number;
      logic [7:0]       first_param;
      logic [7:0]       second_param;
      logic [7:0]       meta_kind;
      logic [LEN_W-1:0] payload_length;
      logic [7:0]       payload_byte;
      logic             last_of_event;
      logic [1:0]       error_code;
      logic             track_end;
   } result_type;

   typedef struct packed {
      logic load;
      logic emit;
   } out_ctl_type;

endpackage

@@ hdl/mtep_if.sv @@
interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       track_start;

   modport source (output valid, data_byte, track_start, input ready);
   modport sink   (input valid, data_byte, track_start, output ready);
endinterface

interface mtep_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [2:0]                 event_kind;
   logic [mtep_pkg::LEN_W-1:0] delta_ticks;
   logic [7:0]                 status_value;
   logic [3:0]                 channel_number;
   logic [7:0]                 first_param;
   logic [7:0]                 second_param;
   logic [7:0]                 meta_kind;
   logic [mtep_pkg::LEN_W-1:0] payload_length;
   logic [7:0]                 payload_byte;
   logic                       last_of_event;
   logic [1:0]                 error_code;
   logic                       track_end;

   modport source (output valid, event_kind, delta_ticks, status_value, channel_number,
                   first_param, second_param, meta_kind, payload_length, payload_byte,
                   last_of_event, error_code, track_end, input ready);
   modport sink   (input valid, event_kind, delta_ticks, status_value, channel_number,
                   first_param, second_param, meta_kind, payload_length, payload_byte,
                   last_of_event, error_code, track_end, output ready);
endinterface

@@ hdl/midi_track_event_parser.sv @@
// Standard MIDI track event parser. Feed the track one byte per req word, with
// track_start set on the first byte of each track; every byte yields at most one
// rsp word (channel event, sysex or meta header, payload byte, or error). A new
// byte is taken every cycle while rsp keeps taking words: the parse state is a
// single register loop updated once per byte, so sustained rate is one byte per
// clock. A byte is caught in the input register when accepted, then parsed into
// the result register when it can take the word, and that register drives rsp.
// While the result register holds a word that rsp does not take, the next byte
// waits in the input register and req drops ready. After an error or end-of-track
// meta event, bytes are dropped silently until the next track_start.
module midi_track_event_parser (
   input  logic       clock,
   input  logic       reset,
   mtep_req_if.sink   req_bus,
   mtep_rsp_if.source rsp_bus
);

   // Input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   // Parse state, advanced once per byte
   mtep_pkg::state_type state_ff;
   mtep_pkg::state_type state_in;

   mtep_pkg::result_type  step_result;
   logic                  step_emit;
   mtep_pkg::out_ctl_type out_ctl;
   logic                  out_can_take;
   logic                  advance;

   // Process the held byte once the result register can take its word
   assign advance       = in_valid_ff && out_can_take;
   assign req_bus.ready = !in_valid_ff || advance;

   assign out_ctl.load = advance;
   assign out_ctl.emit = step_emit;

   always_comb begin
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold the byte until it is parsed
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff  <= req_bus.data_byte;
         in_start_ff <= req_bus.track_start;
      end
   end

   // Advance the parse state only when the byte is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtep_pkg::STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   mtep_step u_step (
      .state_cur (state_ff),
      .byte_cur  (in_byte_ff),
      .start_cur (in_start_ff),
      .state_nxt (state_in),
      .result    (step_result),
      .emit      (step_emit)
   );

   mtep_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .ctl      (out_ctl),
      .result   (step_result),
      .can_take (out_can_take),
      .rsp_bus  (rsp_bus)
   );

endmodule

@@ hdl/mtep_step.sv @@
module mtep_step (
   input  mtep_pkg::state_type  state_cur,
   input  logic [7:0]           byte_cur,
   input  logic                 start_cur,
   output mtep_pkg::state_type  state_nxt,
   output mtep_pkg::result_type result,
   output logic                 emit
);

   localparam logic [3:0] LEN_LIMIT = 4'(mtep_pkg::MAX_LENGTH_BYTES);

   mtep_pkg::state_type       s;
   logic                      fresh;
   logic [7:0]                rs;
   logic [7:0]                cur;
   logic                      dual_param;
   logic                      one_param;
   logic                      is_sysex;
   logic                      is_meta;
   logic [mtep_pkg::LEN_W-1:0] base_acc;
   logic [mtep_pkg::COUNT_W-1:0] base_cnt;
   logic [mtep_pkg::LEN_W-1:0] vl_acc;
   logic [3:0]                vl_n;
   logic                      vl_done;
   logic                      vl_long;
   logic                      take_len;
   logic [mtep_pkg::LEN_W-1:0] rem_dec;
   logic [mtep_pkg::LEN_W-1:0] blk_plen;
   logic                      blk_last;
   logic                      blk_end;

   // Track start wipes running status and any latched error before the byte
   always_comb begin
      s = state_cur;
      if (start_cur) begin
         s.running = '0;
         s.err     = 1'b0;
         s.phase   = mtep_pkg::PH_DELTA;
         s.acc     = '0;
         s.cnt     = '0;
      end
   end

   // Status class, variable-length step and block fields
   always_comb begin
      fresh = byte_cur[7];
      rs    = fresh ? byte_cur : s.running;
      cur   = (s.phase == mtep_pkg::PH_STATUS) ? rs : s.current;
      dual_param = 1'b0;
      one_param = 1'b0;
      unique case (cur[7:4]) inside
         mtep_pkg::NIB_NOTE_OFF, mtep_pkg::NIB_NOTE_ON, mtep_pkg::NIB_POLY_AT,
         mtep_pkg::NIB_CONTROL, mtep_pkg::NIB_BEND: dual_param = 1'b1;
         mtep_pkg::NIB_PROGRAM, mtep_pkg::NIB_CHAN_AT: one_param = 1'b1;
         default: ;
      endcase
      is_sysex = (cur == mtep_pkg::ST_SYSEX) || (cur == mtep_pkg::ST_SYSEX_ESC);
      is_meta  = (cur == mtep_pkg::ST_META);

      base_acc = (s.phase == mtep_pkg::PH_STATUS) ? '0 : s.acc;
      base_cnt = (s.phase == mtep_pkg::PH_STATUS) ? '0 : s.cnt;
      vl_acc   = {base_acc[mtep_pkg::LEN_W-8:0], byte_cur[6:0]};
      vl_n     = {1'b0, base_cnt} + 4'd1;
      vl_done  = !byte_cur[7];
      vl_long  = byte_cur[7] && (vl_n >= LEN_LIMIT);

      take_len = (s.phase == mtep_pkg::PH_LENGTH) ||
                 ((s.phase == mtep_pkg::PH_STATUS) && is_sysex && !fresh);

      rem_dec = s.remaining - mtep_pkg::LEN_W'(1);
      if (s.phase == mtep_pkg::PH_PAYLOAD) begin
         blk_plen = s.acc;
         blk_last = (rem_dec == '0);
      end else begin
         blk_plen = vl_acc;
         blk_last = (vl_acc == '0);
      end
      blk_end = blk_last && is_meta && (s.held_meta == mtep_pkg::META_END);
   end

   // Next state
   always_comb begin
      state_nxt = s;
      if (!s.err) begin
         unique case (s.phase)
            mtep_pkg::PH_DONE: ;
            mtep_pkg::PH_STATUS: begin
               state_nxt.running = rs;
               state_nxt.current = rs;
               if (dual_param) begin
                  if (fresh) begin
                     state_nxt.phase = mtep_pkg::PH_PARAM1;
                  end else begin
                     state_nxt.held_p1 = byte_cur;
                     state_nxt.phase   = mtep_pkg::PH_PARAM2;
                  end
               end else if (one_param) begin
                  if (fresh) begin
                     state_nxt.phase = mtep_pkg::PH_PARAM1;
                  end else begin
                     state_nxt.phase = mtep_pkg::PH_DELTA;
                     state_nxt.acc   = '0;
                     state_nxt.cnt   = '0;
                  end
               end else if (is_sysex) begin
                  state_nxt.acc   = '0;
                  state_nxt.cnt   = '0;
                  state_nxt.phase = mtep_pkg::PH_LENGTH;
               end else if (is_meta) begin
                  if (fresh) begin
                     state_nxt.phase = mtep_pkg::PH_METATYPE;
                  end else begin
                     state_nxt.held_meta = byte_cur;
                     state_nxt.acc       = '0;
                     state_nxt.cnt       = '0;
                     state_nxt.phase     = mtep_pkg::PH_LENGTH;
                  end
               end else begin
                  state_nxt.err = 1'b1;
               end
            end
            mtep_pkg::PH_PARAM1: begin
               if (one_param) begin
                  state_nxt.phase = mtep_pkg::PH_DELTA;
                  state_nxt.acc   = '0;
                  state_nxt.cnt   = '0;
               end else begin
                  state_nxt.held_p1 = byte_cur;
                  state_nxt.phase   = mtep_pkg::PH_PARAM2;
               end
            end
            mtep_pkg::PH_PARAM2: begin
               state_nxt.phase = mtep_pkg::PH_DELTA;
               state_nxt.acc   = '0;
               state_nxt.cnt   = '0;
            end
            mtep_pkg::PH_METATYPE: begin
               state_nxt.held_meta = byte_cur;
               state_nxt.acc       = '0;
               state_nxt.cnt       = '0;
               state_nxt.phase     = mtep_pkg::PH_LENGTH;
            end
            mtep_pkg::PH_LENGTH: ;
            mtep_pkg::PH_PAYLOAD: begin
               state_nxt.remaining = rem_dec;
               if (blk_last) begin
                  if (blk_end) begin
                     state_nxt.phase = mtep_pkg::PH_DONE;
                  end else begin
                     state_nxt.phase = mtep_pkg::PH_DELTA;
                     state_nxt.acc   = '0;
                     state_nxt.cnt   = '0;
                  end
               end
            end
            default: begin
               state_nxt.acc = vl_acc;
               if (vl_long) begin
                  state_nxt.err = 1'b1;
               end else if (vl_done) begin
                  state_nxt.held_delta = vl_acc;
                  state_nxt.phase      = mtep_pkg::PH_STATUS;
               end else begin
                  state_nxt.cnt   = vl_n[mtep_pkg::COUNT_W-1:0];
                  state_nxt.phase = mtep_pkg::PH_DELTA;
               end
            end
         endcase

         // Payload length byte, also reached by running status on sysex
         if (take_len) begin
            state_nxt.acc = vl_acc;
            if (vl_long) begin
               state_nxt.err = 1'b1;
            end else if (!vl_done) begin
               state_nxt.cnt = vl_n[mtep_pkg::COUNT_W-1:0];
            end else begin
               state_nxt.remaining = vl_acc;
               state_nxt.phase     = mtep_pkg::PH_PAYLOAD;
               if (blk_last) begin
                  if (blk_end) begin
                     state_nxt.phase = mtep_pkg::PH_DONE;
                  end else begin
                     state_nxt.phase = mtep_pkg::PH_DELTA;
                     state_nxt.acc   = '0;
                     state_nxt.cnt   = '0;
                  end
               end
            end
         end
      end
   end

   // Result word
   always_comb begin
      result = '0;
      emit   = 1'b0;
      if (!s.err) begin
         unique case (s.phase)
            mtep_pkg::PH_STATUS: begin
               if (dual_param || is_sysex || is_meta) begin
                  emit = 1'b0;
               end else if (one_param) begin
                  if (!fresh) begin
                     emit                  = 1'b1;
                     result.event_kind     = mtep_pkg::KIND_CHANNEL;
                     result.delta_ticks    = s.held_delta;
                     result.status_value   = {cur[7:4], 4'h0};
                     result.channel_number = cur[3:0];
                     result.first_param    = byte_cur;
                     result.last_of_event  = 1'b1;
                  end
               end else begin
                  emit                 = 1'b1;
                  result.event_kind    = mtep_pkg::KIND_ERROR;
                  result.delta_ticks   = s.held_delta;
                  result.status_value  = rs;
                  result.error_code    = mtep_pkg::ERR_UNKNOWN;
                  result.last_of_event = 1'b1;
               end
            end
            mtep_pkg::PH_PARAM1: begin
               if (one_param) begin
                  emit                  = 1'b1;
                  result.event_kind     = mtep_pkg::KIND_CHANNEL;
                  result.delta_ticks    = s.held_delta;
                  result.status_value   = {cur[7:4], 4'h0};
                  result.channel_number = cur[3:0];
                  result.first_param    = byte_cur;
                  result.last_of_event  = 1'b1;
               end
            end
            mtep_pkg::PH_PARAM2: begin
               emit                  = 1'b1;
               result.event_kind     = mtep_pkg::KIND_CHANNEL;
               result.delta_ticks    = s.held_delta;
               result.status_value   = {cur[7:4], 4'h0};
               result.channel_number = cur[3:0];
               result.first_param    = s.held_p1;
               result.second_param   = byte_cur;
               result.last_of_event  = 1'b1;
            end
            mtep_pkg::PH_PAYLOAD: begin
               emit                  = 1'b1;
               result.event_kind     = mtep_pkg::KIND_PAYLOAD;
               result.delta_ticks    = s.held_delta;
               result.status_value   = cur;
               result.meta_kind      = is_meta ? s.held_meta : 8'h00;
               result.payload_length = blk_plen;
               result.payload_byte   = byte_cur;
               result.last_of_event  = blk_last;
               result.track_end      = blk_end;
            end
            mtep_pkg::PH_DELTA: begin
               if (vl_long) begin
                  emit                 = 1'b1;
                  result.event_kind    = mtep_pkg::KIND_ERROR;
                  result.error_code    = mtep_pkg::ERR_TOO_LONG;
                  result.last_of_event = 1'b1;
               end
            end
            default: ;
         endcase

         if (take_len) begin
            if (vl_long) begin
               emit                 = 1'b1;
               result.event_kind    = mtep_pkg::KIND_ERROR;
               result.delta_ticks   = s.held_delta;
               result.status_value  = cur;
               result.error_code    = mtep_pkg::ERR_TOO_LONG;
               result.last_of_event = 1'b1;
            end else if (vl_done) begin
               emit                  = 1'b1;
               result.event_kind     = is_meta ? mtep_pkg::KIND_META : mtep_pkg::KIND_SYSEX;
               result.delta_ticks    = s.held_delta;
               result.status_value   = cur;
               result.meta_kind      = is_meta ? s.held_meta : 8'h00;
               result.payload_length = blk_plen;
               result.last_of_event  = blk_last;
               result.track_end      = blk_end;
            end
         end
      end
   end

endmodule

@@ hdl/mtep_out_reg.sv @@
module mtep_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  mtep_pkg::out_ctl_type ctl,
   input  mtep_pkg::result_type  result,
   output logic                 can_take,
   mtep_rsp_if.source           rsp_bus
);

   logic                 out_valid_ff;
   logic                 out_valid_in;
   mtep_pkg::result_type out_data_ff;

   assign can_take = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      if (ctl.load) begin
         out_valid_in = ctl.emit;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load && ctl.emit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.event_kind     = out_data_ff.event_kind;
   assign rsp_bus.delta_ticks    = out_data_ff.delta_ticks;
   assign rsp_bus.status_value   = out_data_ff.status_value;
   assign rsp_bus.channel_number = out_data_ff.channel_number;
   assign rsp_bus.first_param    = out_data_ff.first_param;
   assign rsp_bus.second_param   = out_data_ff.second_param;
   assign rsp_bus.meta_kind      = out_data_ff.meta_kind;
   assign rsp_bus.payload_length = out_data_ff.payload_length;
   assign rsp_bus.payload_byte   = out_data_ff.payload_byte;
   assign rsp_bus.last_of_event  = out_data_ff.last_of_event;
   assign rsp_bus.error_code     = out_data_ff.error_code;
   assign rsp_bus.track_end      = out_data_ff.track_end;

endmodule

@@ tb/midi_event_checker.sv @@
// Watches both channels of the MIDI track event parser, predicts the result word
// for every byte taken and compares it with the words the block hands out.
module midi_event_checker
   import mtep_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mtep_req_if  req_mon,
   mtep_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {VLQ_MORE, VLQ_DONE, VLQ_TOO_LONG} vlq_step_type;

   // Parser state as the prediction sees it
   phase_type          pred_phase;
   logic [LEN_W-1:0]   len_acc;
   logic [COUNT_W-1:0] len_count;
   logic [7:0]         running_st;
   logic [7:0]         current_st;
   logic [LEN_W-1:0]   delta_hold;
   logic [7:0]         param_hold;
   logic [7:0]         meta_hold;
   logic [LEN_W-1:0]   bytes_left;
   logic               error_seen;

   result_type predicted;
   logic       predicted_valid;
   result_type expected_events[$];
   result_type observed;
   result_type oldest;

   function automatic int param_count(input logic [3:0] nib);
      if (nib == NIB_PROGRAM || nib == NIB_CHAN_AT) return 1;
      if (nib == NIB_NOTE_OFF || nib == NIB_NOTE_ON || nib == NIB_POLY_AT ||
          nib == NIB_CONTROL || nib == NIB_BEND) return 2;
      return 0;
   endfunction

   function automatic string describe(input result_type r);
      return $sformatf({"kind=%0d delta=%07h status=%02h chan=%0h p1=%02h p2=%02h ",
                        "meta=%02h len=%07h byte=%02h last=%0b err=%0d end=%0b"},
                       r.event_kind, r.delta_ticks, r.status_value, r.channel_number,
                       r.first_param, r.second_param, r.meta_kind, r.payload_length,
                       r.payload_byte, r.last_of_event, r.error_code, r.track_end);
   endfunction

   task automatic clear_length();
      len_acc   = '0;
      len_count = '0;
   endtask

   task automatic shift_length_byte(input logic [7:0] b, output vlq_step_type r);
      int n;
      n = int'(len_count) + 1;
      len_acc = {len_acc[LEN_W-8:0], b[6:0]};
      if (!b[7]) begin
         r = VLQ_DONE;
      end else if (n >= MAX_LENGTH_BYTES) begin
         r = VLQ_TOO_LONG;
      end else begin
         len_count = COUNT_W'(n);
         r = VLQ_MORE;
      end
   endtask

   task automatic raise_error(input logic [1:0] code, input logic [LEN_W-1:0] delta,
                              input logic [7:0] status);
      predicted.event_kind    = KIND_ERROR;
      predicted.delta_ticks   = delta;
      predicted.status_value  = status;
      predicted.error_code    = code;
      predicted.last_of_event = 1'b1;
      predicted_valid         = 1'b1;
      error_seen              = 1'b1;
   endtask

   task automatic finish_channel(input logic [7:0] p1, input logic [7:0] p2);
      predicted.event_kind     = KIND_CHANNEL;
      predicted.delta_ticks    = delta_hold;
      predicted.status_value   = {current_st[7:4], 4'h0};
      predicted.channel_number = current_st[3:0];
      predicted.first_param    = p1;
      predicted.second_param   = p2;
      predicted.last_of_event  = 1'b1;
      predicted_valid          = 1'b1;
      pred_phase               = PH_DELTA;
      clear_length();
   endtask

   // Header or payload word of a sysex or meta event
   task automatic fill_block(input logic [2:0] kind, input logic last);
      logic is_end;
      is_end = last && current_st == ST_META && meta_hold == META_END;
      predicted.event_kind     = kind;
      predicted.delta_ticks    = delta_hold;
      predicted.status_value   = current_st;
      predicted.meta_kind      = (current_st == ST_META) ? meta_hold : 8'h00;
      predicted.payload_length = len_acc;
      predicted.last_of_event  = last;
      predicted.track_end      = is_end;
      predicted_valid          = 1'b1;
      if (last) begin
         if (is_end) begin
            pred_phase = PH_DONE;
         end else begin
            pred_phase = PH_DELTA;
            clear_length();
         end
      end
   endtask

   task automatic take_length(input logic [7:0] b);
      vlq_step_type r;
      shift_length_byte(b, r);
      if (r == VLQ_TOO_LONG) begin
         raise_error(ERR_TOO_LONG, delta_hold, current_st);
      end else if (r == VLQ_DONE) begin
         bytes_left = len_acc;
         pred_phase = PH_PAYLOAD;
         fill_block((current_st == ST_META) ? KIND_META : KIND_SYSEX, len_acc == '0);
      end
   endtask

   task automatic decode_track_byte(input logic [7:0] b, input logic start);
      logic         fresh;
      vlq_step_type r;
      predicted       = '0;
      predicted_valid = 1'b0;
      if (start) begin
         running_st = 8'h00;
         error_seen = 1'b0;
         pred_phase = PH_DELTA;
         clear_length();
      end
      if (error_seen || pred_phase == PH_DONE) return;
      case (pred_phase)
         PH_STATUS: begin
            fresh = b[7];
            if (fresh) running_st = b;
            current_st = running_st;
            case (param_count(current_st[7:4]))
               2: begin
                  if (fresh) begin
                     pred_phase = PH_PARAM1;
                  end else begin
                     param_hold = b;
                     pred_phase = PH_PARAM2;
                  end
               end
               1: begin
                  if (fresh) pred_phase = PH_PARAM1;
                  else finish_channel(b, 8'h00);
               end
               default: begin
                  if (current_st == ST_SYSEX || current_st == ST_SYSEX_ESC) begin
                     clear_length();
                     pred_phase = PH_LENGTH;
                     if (!fresh) take_length(b);
                  end else if (current_st == ST_META) begin
                     if (fresh) begin
                        pred_phase = PH_METATYPE;
                     end else begin
                        meta_hold = b;
                        clear_length();
                        pred_phase = PH_LENGTH;
                     end
                  end else begin
                     raise_error(ERR_UNKNOWN, delta_hold, current_st);
                  end
               end
            endcase
         end
         PH_PARAM1: begin
            if (param_count(current_st[7:4]) == 1) begin
               finish_channel(b, 8'h00);
            end else begin
               param_hold = b;
               pred_phase = PH_PARAM2;
            end
         end
         PH_PARAM2: finish_channel(param_hold, b);
         PH_METATYPE: begin
            meta_hold = b;
            clear_length();
            pred_phase = PH_LENGTH;
         end
         PH_LENGTH: take_length(b);
         PH_PAYLOAD: begin
            bytes_left = bytes_left - 1'b1;
            predicted.payload_byte = b;
            fill_block(KIND_PAYLOAD, bytes_left == '0);
         end
         default: begin
            shift_length_byte(b, r);
            if (r == VLQ_TOO_LONG) begin
               raise_error(ERR_TOO_LONG, '0, 8'h00);
            end else if (r == VLQ_DONE) begin
               delta_hold = len_acc;
               pred_phase = PH_STATUS;
            end else begin
               pred_phase = PH_DELTA;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pred_phase     = PH_DELTA;
         running_st     = 8'h00;
         current_st     = 8'h00;
         delta_hold     = '0;
         param_hold     = 8'h00;
         meta_hold      = 8'h00;
         bytes_left     = '0;
         error_seen     = 1'b0;
         clear_length();
         expected_events.delete();
         mismatch_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            decode_track_byte(req_mon.data_byte, req_mon.track_start);
            if (predicted_valid) expected_events.push_back(predicted);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            observed.event_kind     = rsp_mon.event_kind;
            observed.delta_ticks    = rsp_mon.delta_ticks;
            observed.status_value   = rsp_mon.status_value;
            observed.channel_number = rsp_mon.channel_number;
            observed.first_param    = rsp_mon.first_param;
            observed.second_param   = rsp_mon.second_param;
            observed.meta_kind      = rsp_mon.meta_kind;
            observed.payload_length = rsp_mon.payload_length;
            observed.payload_byte   = rsp_mon.payload_byte;
            observed.last_of_event  = rsp_mon.last_of_event;
            observed.error_code     = rsp_mon.error_code;
            observed.track_end      = rsp_mon.track_end;
            if (expected_events.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result word with nothing expected: %s", $realtime,
                           describe(observed));
            end else begin
               oldest = expected_events.pop_front();
               if (observed !== oldest) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                              $realtime, describe(oldest), describe(observed));
               end
            end
         end
      end
      outstanding = expected_events.size();
   end

endmodule

@@ tb/tb_midi_track_event_parser.sv @@
module tb_midi_track_event_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import mtep_pkg::*;

   // Quiet cycles (no word moved on either side) before the run is abandoned
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 700;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mtep_req_if req_bus ();
   mtep_rsp_if rsp_bus ();

   int mismatch_count;
   int outstanding;

   // Stimulus bookkeeping
   int         send_idle_pct = 10;
   int         recv_idle_pct = 61;
   int         items_sent    = 0;
   logic       start_next    = 1'b1;  // next byte opens a new track
   logic       stray_starts  = 1'b0;  // allow track_start on arbitrary bytes
   logic [7:0] running_mirror = 8'h00;  // our idea of the running status

   midi_track_event_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   midi_event_checker event_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result side: drop ready at random, changing only on the falling edge
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Abandon the run when no word moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_midi_track_event_parser: done, errors");
      $finish;
   end

   // Present one word and hold it until it is taken. Entered and left on a
   // falling edge; valid is only touched once per edge, so back-to-back words
   // keep it high.
   task automatic send_byte(input logic [7:0] b, input logic start);
      items_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.track_start <= start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Send one byte of a track; the first byte of a track carries track_start
   task automatic put(input logic [7:0] b);
      logic start;
      start = start_next || (stray_starts && $urandom_range(199) == 0);
      if (start) running_mirror = 8'h00;
      start_next = 1'b0;
      send_byte(b, start);
   endtask

   // Variable-length quantity of n bytes: low 7*n bits of value, most
   // significant group first, continuation bit on all but the last
   task automatic put_varlen(input logic [LEN_W-1:0] value, input int n);
      logic [34:0] v;
      logic [7:0]  b;
      v = {7'd0, value};
      for (int i = n - 1; i >= 0; i--) begin
         b = {(i != 0), v[7*i +: 7]};
         put(b);
      end
   endtask

   // Mostly one-byte deltas, now and then up to four
   task automatic put_delta();
      int pick;
      pick = $urandom_range(9);
      put_varlen(LEN_W'($urandom), (pick < 6) ? 1 : (pick < 8) ? 2 : pick - 5);
   endtask

   // Short payload length, sometimes padded with leading zero groups
   task automatic put_length(input int len);
      put_varlen(LEN_W'(len), ($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1);
   endtask

   task automatic put_payload(input int n);
      repeat (n) put(8'($urandom));
   endtask

   function automatic logic [7:0] param_value();
      return ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
   endfunction

   // Leave the track: a few bytes the parser should drop, then a new track
   task automatic abandon_track();
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
      start_next     = 1'b1;
      running_mirror = 8'h00;
   endtask

   task automatic play_track(input logic [7:0] seq[$]);
      start_next     = 1'b1;
      running_mirror = 8'h00;
      foreach (seq[i]) put(seq[i]);
   endtask

   task automatic run_directed();
      logic [7:0] track[$];
      // Every channel nibble, running status, delta extremes, sysex and meta
      // with and without running status, and an over-long payload length
      track = '{8'h00, 8'h90, 8'h3C, 8'h40,
                8'h81, 8'h00, 8'h3C, 8'h00,
                8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hC5, 8'h7F,
                8'h00, 8'h20,
                8'h00, 8'h8F, 8'h00, 8'h7F,
                8'h00, 8'hA3, 8'h40, 8'h80,
                8'h00, 8'hB7, 8'h07, 8'h64,
                8'h00, 8'hD9, 8'h30,
                8'h00, 8'hEE, 8'h00, 8'h40,
                8'h00, 8'hF0, 8'h03, 8'h01, 8'h02, 8'h03,
                8'h00, 8'hF7, 8'h00,
                8'h00, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44, 8'hFF,
                8'h00, 8'hFF, 8'h01, 8'h02, 8'h41, 8'h42,
                8'h00, 8'hFF, 8'h7F, 8'h00,
                8'h00, 8'h03, 8'h00,
                8'h00, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h12, 8'h34};
      play_track(track);
      // Largest payload length, cut short by the next track
      track = '{8'h00, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hAA, 8'hBB};
      play_track(track);
      // Data byte straight after track start: running status is still empty
      track = '{8'h00, 8'h40, 8'h90};
      play_track(track);
      // System status the parser does not know
      track = '{8'h60, 8'hF4};
      play_track(track);
      // Delta time with a fifth byte
      track = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h55};
      play_track(track);
      // End of track, with nothing and with one payload byte, then dropped bytes
      track = '{8'h00, 8'hFF, 8'h2F, 8'h00, 8'h00, 8'h90};
      play_track(track);
      track = '{8'h00, 8'hFF, 8'h2F, 8'h01, 8'hAA, 8'h00};
      play_track(track);
      // Track start in the middle of a payload
      track = '{8'h00, 8'hF0, 8'h05, 8'h01};
      play_track(track);
      track = '{8'h00, 8'hC0, 8'h00};
      play_track(track);
   endtask

   // One random event; mostly well formed, now and then broken on purpose
   task automatic put_event();
      int         pick;
      int         len;
      logic [3:0] nib;
      logic [7:0] st;
      logic [7:0] meta_type;
      logic [LEN_W-1:0] big_len;
      pick = $urandom_range(99);
      if (pick < 3) begin
         // continuation bit on the fourth delta byte
         put_varlen(LEN_W'($urandom), 5);
         abandon_track();
         return;
      end
      put_delta();
      if (pick < 55) begin
         if (running_mirror[7:4] >= NIB_NOTE_OFF && running_mirror[7:4] <= NIB_BEND &&
             $urandom_range(1)) begin
            nib = running_mirror[7:4];
            put(8'($urandom_range(0, 127)));
         end else begin
            nib = 4'($urandom_range(8, 14));
            st  = {nib, 4'($urandom_range(0, 15))};
            put(st);
            running_mirror = st;
            put(param_value());
         end
         if (nib != NIB_PROGRAM && nib != NIB_CHAN_AT) put(param_value());
      end else if (pick < 67) begin
         if ((running_mirror == ST_SYSEX || running_mirror == ST_SYSEX_ESC) &&
             $urandom_range(1)) begin
            // data byte under running sysex is the length itself
            len = $urandom_range(0, 4);
            put(8'(len));
         end else begin
            st = $urandom_range(1) ? ST_SYSEX : ST_SYSEX_ESC;
            put(st);
            running_mirror = st;
            len = $urandom_range(0, 6);
            put_length(len);
         end
         put_payload(len);
      end else if (pick < 82) begin
         if (running_mirror == ST_META && $urandom_range(1)) begin
            meta_type = 8'($urandom_range(0, 127));
            if (meta_type == META_END) meta_type = 8'h01;
            put(meta_type);
         end else begin
            meta_type = 8'($urandom);
            if (meta_type == META_END) meta_type = 8'h51;
            put(ST_META);
            running_mirror = ST_META;
            put(meta_type);
         end
         len = $urandom_range(0, 5);
         put_length(len);
         put_payload(len);
      end else if (pick < 88) begin
         if (running_mirror != ST_META || $urandom_range(1)) put(ST_META);
         put(META_END);
         len = $urandom_range(0, 2);
         put_length(len);
         put_payload(len);
         abandon_track();
      end else if (pick < 92) begin
         if (running_mirror == 8'h00) put(8'($urandom_range(0, 127)));
         else put(8'($urandom_range(8'hF1, 8'hFE)));
         abandon_track();
      end else if (pick < 96) begin
         if ($urandom_range(1)) begin
            put(ST_META);
            put(8'($urandom_range(0, 127)));
         end else begin
            put(ST_SYSEX);
         end
         put_varlen(LEN_W'($urandom), 5);
         abandon_track();
      end else begin
         // huge length: take a few payload bytes and move on
         big_len = ($urandom_range(3) == 0) ? {LEN_W{1'b1}} : LEN_W'($urandom);
         put(ST_SYSEX_ESC);
         put_varlen(big_len, 4);
         put_payload($urandom_range(1, 4));
         abandon_track();
      end
   endtask

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = 8'h00;
      req_bus.track_start = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      // Random tracks; swap the idle pattern a third and two thirds of the way in
      start_next     = 1'b1;
      running_mirror = 8'h00;
      stray_starts   = 1'b1;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (items_sent >= RANDOM_ITEMS / 3) begin
            send_idle_pct = 61;
            recv_idle_pct = 10;
         end
         put_event();
      end
      req_bus.valid <= 1'b0;

      // Drain, then give the pipeline time to show any stray word
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      if (mismatch_count == 0)
         $display("tb_midi_track_event_parser: done, clean");
      else
         $display("tb_midi_track_event_parser: done, errors");
      $finish;
   end

endmodule
